/* rtl/core/pbx_pkg.sv */
`timescale 1ns / 1ps
// Package for the packet body XOR cipher: command codes, constants and the
// beat structs shared by the core and the top level.
package pbx_pkg;

  localparam logic [1:0] CMD_KEY_WR = 2'd0;
  localparam logic [1:0] CMD_ARM    = 2'd1;
  localparam logic [1:0] CMD_ENC    = 2'd2;
  localparam logic [1:0] CMD_DEC    = 2'd3;

  localparam logic [15:0] HEADER_BYTES = 16'd8;
  localparam logic [7:0]  IDX_SALT     = 8'h02;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  key_addr;
    logic [7:0]  key_value;
    logic [7:0]  start_index;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic        no_body;
    logic [15:0] packet_length;
    logic [7:0]  header_key_index;
    logic [7:0]  header_encrypted;
  } pbx_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] out_key_index;
    logic       out_encrypted;
    logic       out_last;
  } pbx_result_t;

  typedef struct packed {
    logic keys_ready;
    logic packet_active;
  } pbx_status_t;

endpackage

/* rtl/core/pbx_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result beats.
// Standalone; no package dependency.
interface pbx_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  key_addr;
  logic [7:0]  key_value;
  logic [7:0]  start_index;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        last_byte;
  logic        no_body;
  logic [15:0] packet_length;
  logic [7:0]  header_key_index;
  logic [7:0]  header_encrypted;

  modport source (output valid, cmd, key_addr, key_value, start_index, data_byte,
                  first_byte, last_byte, no_body, packet_length, header_key_index,
                  header_encrypted, input ready);
  modport sink (input valid, cmd, key_addr, key_value, start_index, data_byte,
                first_byte, last_byte, no_body, packet_length, header_key_index,
                header_encrypted, output ready);
endinterface

interface pbx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [7:0] out_key_index;
  logic       out_encrypted;
  logic       out_last;

  modport source (output valid, out_byte, out_key_index, out_encrypted, out_last,
                  input ready);
  modport sink (input valid, out_byte, out_key_index, out_encrypted, out_last,
                output ready);
endinterface

/* rtl/core/packet_body_xor_cipher_unit.sv */
`timescale 1ns / 1ps
// Packet body XOR cipher, top level. The key table read feeds the stage-1
// register; the transform feeds the output register. One beat per cycle
// unless the output stalls; for encrypt beats the key read address forwards
// the next index of the beat in the transform stage. Synchronous active-low
// reset clears all cipher state and the key table valid bits; no clearing pass.
module packet_body_xor_cipher_unit (
  input  logic clk,
  input  logic rst_n,
  pbx_in_if.sink    in_if,
  pbx_out_if.source out_if
);

  pbx_pkg::pbx_item_t   in_item, s1_item_r;
  pbx_pkg::pbx_result_t res, out_r;
  pbx_pkg::pbx_status_t status;
  logic       s1_valid_r, out_valid_r;
  logic       in_ready, accept, s1_adv, has_out;
  logic [7:0] next_index_fwd, key_byte, rd_addr;

  always_comb begin
    in_item.cmd              = in_if.cmd;
    in_item.key_addr         = in_if.key_addr;
    in_item.key_value        = in_if.key_value;
    in_item.start_index      = in_if.start_index;
    in_item.data_byte        = in_if.data_byte;
    in_item.first_byte       = in_if.first_byte;
    in_item.last_byte        = in_if.last_byte;
    in_item.no_body          = in_if.no_body;
    in_item.packet_length    = in_if.packet_length;
    in_item.header_key_index = in_if.header_key_index;
    in_item.header_encrypted = in_if.header_encrypted;
  end

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_if.valid && in_ready;
  assign rd_addr  = (in_if.cmd == pbx_pkg::CMD_ENC) ? next_index_fwd
                                                     : in_if.header_key_index;

  pbx_key_mem u_key_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept && (in_if.cmd == pbx_pkg::CMD_KEY_WR)),
    .wr_addr (in_if.key_addr),
    .wr_data (in_if.key_value),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (key_byte)
  );

  pbx_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .item           (s1_item_r),
    .key_byte       (key_byte),
    .adv            (s1_adv),
    .res            (res),
    .has_out        (has_out),
    .next_index_fwd (next_index_fwd),
    .status         (status)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
    if (s1_adv && has_out) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv && has_out) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_if.ready          = in_ready;
  assign out_if.valid         = out_valid_r;
  assign out_if.out_byte      = out_r.out_byte;
  assign out_if.out_key_index = out_r.out_key_index;
  assign out_if.out_encrypted = out_r.out_encrypted;
  assign out_if.out_last      = out_r.out_last;

  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && has_out))
    else $error("result beat without a transformed item");

  a_arm_sets_ready: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (s1_item_r.cmd == pbx_pkg::CMD_ARM) |=> status.keys_ready)
    else $error("arm did not set keys ready");

  a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    status.keys_ready |=> status.keys_ready)
    else $error("keys ready dropped");

  a_arm_ends_packet: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (s1_item_r.cmd == pbx_pkg::CMD_ARM) |=> !status.packet_active)
    else $error("arm left a packet active");

endmodule

/* rtl/core/pbx_key_mem.sv */
`timescale 1ns / 1ps
// 256 x 8 key table, one write and one registered read port.
// Per-entry valid bits make unwritten entries read as zero. No package dependency.
module pbx_key_mem (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [7:0] wr_addr,
  input  logic [7:0] wr_data,
  input  logic       rd_en,
  input  logic [7:0] rd_addr,
  output logic [7:0] rd_data
);

  logic [7:0]   mem [256];
  logic [255:0] vld_r;
  logic [7:0]   rd_data_r;
  logic         rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : 8'd0;

endmodule

/* rtl/core/pbx_core.sv */
`timescale 1ns / 1ps
// Cipher state and per-beat transform: running obfuscator, byte position,
// packet and next key index. Uses pbx_pkg types and command codes.
module pbx_core (
  input  logic                clk,
  input  logic                rst_n,
  input  pbx_pkg::pbx_item_t  item,
  input  logic [7:0]          key_byte,
  input  logic                adv,
  output pbx_pkg::pbx_result_t res,
  output logic                has_out,
  output logic [7:0]          next_index_fwd,
  output pbx_pkg::pbx_status_t status
);

  logic        keys_ready_r, keys_ready_nxt;
  logic        active_r, active_nxt;
  logic [7:0]  next_index_r, next_index_nxt;
  logic [7:0]  obf_r, obf_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [7:0]  pidx_r, pidx_nxt;

  logic        enc_go, dec_go, start, xform;
  logic [7:0]  idx, obf_base, obf_new, pidx_cur;
  logic [15:0] pos_cur;

  always_comb begin
    enc_go   = (item.cmd == pbx_pkg::CMD_ENC) && keys_ready_r;
    dec_go   = (item.cmd == pbx_pkg::CMD_DEC) && keys_ready_r &&
               (item.header_encrypted != 8'd0);
    start    = item.first_byte || !active_r;
    xform    = (enc_go || dec_go) && !item.no_body;
    idx      = enc_go ? next_index_r : item.header_key_index;
    obf_base = start ? (key_byte + idx + 8'd1) : obf_r;
    pos_cur  = start ? pbx_pkg::HEADER_BYTES : pos_r;
    pidx_cur = start ? idx : pidx_r;
    obf_new  = obf_base + pos_cur[7:0] + pos_cur[15:8];

    has_out = (item.cmd == pbx_pkg::CMD_ENC) || (item.cmd == pbx_pkg::CMD_DEC);
    res.out_last = item.no_body || item.last_byte;
    if (enc_go) begin
      res.out_byte      = item.no_body ? 8'd0
                          : (item.data_byte ^ obf_new ^ (pidx_cur + pbx_pkg::IDX_SALT));
      res.out_key_index = item.no_body ? next_index_r : pidx_cur;
      res.out_encrypted = 1'b1;
    end else if (dec_go) begin
      res.out_byte      = item.no_body ? 8'd0
                          : (item.data_byte ^ obf_new ^ (pidx_cur + pbx_pkg::IDX_SALT));
      res.out_key_index = 8'd0;
      res.out_encrypted = 1'b0;
    end else begin
      res.out_byte      = item.no_body ? 8'd0 : item.data_byte;
      res.out_key_index = item.header_key_index;
      res.out_encrypted = item.header_encrypted != 8'd0;
    end

    keys_ready_nxt = keys_ready_r;
    active_nxt     = active_r;
    next_index_nxt = next_index_r;
    obf_nxt        = obf_r;
    pos_nxt        = pos_r;
    pidx_nxt       = pidx_r;
    if (adv) begin
      case (item.cmd)
        pbx_pkg::CMD_ARM: begin
          next_index_nxt = item.start_index;
          keys_ready_nxt = 1'b1;
          active_nxt     = 1'b0;
        end
        pbx_pkg::CMD_ENC, pbx_pkg::CMD_DEC: begin
          if (enc_go || dec_go) begin
            if (item.no_body) begin
              active_nxt = 1'b0;
              if (enc_go) begin
                next_index_nxt = next_index_r + item.packet_length[7:0];
              end
            end else begin
              obf_nxt    = obf_new;
              pos_nxt    = pos_cur + 16'd1;
              pidx_nxt   = pidx_cur;
              active_nxt = !item.last_byte;
              if (enc_go && item.last_byte) begin
                next_index_nxt = pidx_cur + item.packet_length[7:0];
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_ready_r <= 1'b0;
      active_r     <= 1'b0;
      next_index_r <= 8'd0;
      obf_r        <= 8'd0;
      pos_r        <= 16'd0;
      pidx_r       <= 8'd0;
    end else begin
      keys_ready_r <= keys_ready_nxt;
      active_r     <= active_nxt;
      next_index_r <= next_index_nxt;
      obf_r        <= obf_nxt;
      pos_r        <= pos_nxt;
      pidx_r       <= pidx_nxt;
    end
  end

  assign next_index_fwd       = next_index_nxt;
  assign status.keys_ready    = keys_ready_r;
  assign status.packet_active = active_r;

endmodule
